// File: hdl/hpt_pkg.sv
// hpt_pkg: widths, types and reset constants of the homogeneous point transform.
// Depends on nothing; used by hpt_mat, hpt_inv, the top level and the testbench.
`default_nettype none

package hpt_pkg;

    localparam int unsigned COORD_W   = 32;               // Q16.16 entry and point
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned PROD_W    = 2 * COORD_W;      // 32x32 product
    localparam int unsigned HALF_W    = COORD_W;          // split point of wide operands
    localparam int unsigned OUT_W     = 48;               // Q32.16 result
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned CFG_N     = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ADJ_W     = 64;               // adjugate entry
    localparam int unsigned SCALE_W   = 32;               // |M33|
    localparam int unsigned DIFF_W    = COORD_W + 1;      // p - t
    localparam int unsigned QDIV_QW   = DIFF_W + FRAC_W;  // inverse pre-scale quotient
    localparam int unsigned QS_W      = QDIV_QW + 1;      // signed pre-scaled point
    localparam int unsigned FROW_W    = PROD_W + 2;       // forward row sum
    localparam int unsigned NUM_W     = 116;              // numerator, both modes
    localparam int unsigned DET_W     = 98;               // determinant / divisor
    localparam int unsigned FDIV_QW   = OUT_W;            // final quotient bits
    localparam int unsigned OVF_SH    = FDIV_QW - FRAC_W; // overflow test shift

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] t_entry;
    typedef logic signed [ADJ_W-1:0]   t_adj;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_INV = 1'b1
    } t_opcode;

    // Matrix-derived values, settled once a register write has passed the hpt_mat registers
    typedef struct packed {
        logic [DET_W-1:0]   det_mag;
        logic               det_neg;
        logic               det_zero;
        logic [SCALE_W-1:0] scale_mag;
        logic               scale_neg;
        logic               scale_zero;
    } t_mat_info;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_N] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    // Cyclic neighbours for cofactor indexing
    localparam int unsigned NXT [3] = '{1, 2, 0};
    localparam int unsigned PRV [3] = '{2, 0, 1};

endpackage

`default_nettype wire

// File: hdl/hpt_div.sv
// hpt_div: pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Depends on nothing.
`default_nettype none

module hpt_div #(
    parameter int unsigned LANES = 3,
    parameter int unsigned DW    = 32,
    parameter int unsigned QW    = 48,
    parameter int unsigned PW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [DW-1:0]              i_den,
    input  logic [LANES-1:0][DW-1:0]   i_rem,   // must be below i_den
    input  logic [LANES-1:0][QW-1:0]   i_low,
    input  logic [PW-1:0]              i_pay,
    output logic                       o_valid,
    output logic [LANES-1:0][QW-1:0]   o_quo,
    output logic [PW-1:0]              o_pay
);

    logic [QW:0]               r_vld;
    logic [DW-1:0]             r_den [QW];
    logic [LANES-1:0][DW-1:0]  r_rem [QW];
    logic [LANES-1:0][QW-1:0]  r_low [QW+1];
    logic [PW-1:0]             r_pay [QW+1];
    logic [LANES-1:0][DW-1:0]  n_rem [QW];
    logic [LANES-1:0][QW-1:0]  n_low [QW];

    // low word: numerator bits shift out at the top, quotient bits in at the bottom
    always_comb begin
        logic [DW:0] t;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                t = {r_rem[k][l], r_low[k][l][QW-1]};
                if (t >= {1'b0, r_den[k]}) begin
                    n_rem[k][l] = DW'(t - {1'b0, r_den[k]});
                    n_low[k][l] = {r_low[k][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = t[DW-1:0];
                    n_low[k][l] = {r_low[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0] <= i_den;
        r_rem[0] <= i_rem;
        r_low[0] <= i_low;
        r_pay[0] <= i_pay;
        for (int k = 0; k < QW - 1; k++) begin
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= n_rem[k];
        end
        for (int k = 0; k < QW; k++) begin
            r_low[k+1] <= n_low[k];
            r_pay[k+1] <= r_pay[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_low[QW];
    assign o_pay   = r_pay[QW];

endmodule

`default_nettype wire

// File: hdl/hpt_mat.sv
// hpt_mat: matrix-side arithmetic (adjugate, determinant, scale) recomputed every cycle
// from the configuration registers. Depends on hpt_pkg.
`default_nettype none

module hpt_mat (
    input  logic                i_clk,
    input  hpt_pkg::t_entry     i_m [4][4],
    output hpt_pkg::t_adj       o_adj [3][3],
    output hpt_pkg::t_mat_info  o_info
);

    import hpt_pkg::*;

    t_adj                       r_pa [3][3];
    t_adj                       r_pb [3][3];
    t_adj                       r_adj [3][3];
    logic signed [PROD_W-1:0]   r_ph [3];
    logic signed [PROD_W:0]     r_pl [3];
    logic signed [DET_W-1:0]    r_prod [3];
    logic signed [DET_W-1:0]    r_det;
    t_mat_info                  r_info;

    always_ff @(posedge i_clk) begin
        // cofactor products
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_pa[r][c] <= $signed(i_m[NXT[c]][NXT[r]]) * $signed(i_m[PRV[c]][PRV[r]]);
                r_pb[r][c] <= $signed(i_m[NXT[c]][PRV[r]]) * $signed(i_m[PRV[c]][NXT[r]]);
                r_adj[r][c] <= r_pa[r][c] - r_pb[r][c];
            end
        end
        // det = sum M0c * adj[c][0], adjugate split into halves
        for (int c = 0; c < 3; c++) begin
            r_ph[c]   <= $signed(i_m[0][c]) * $signed(r_adj[c][0][ADJ_W-1:HALF_W]);
            r_pl[c]   <= $signed(i_m[0][c]) * $signed({1'b0, r_adj[c][0][HALF_W-1:0]});
            r_prod[c] <= (DET_W'(r_ph[c]) <<< HALF_W) + DET_W'(r_pl[c]);
        end
        r_det <= r_prod[0] + r_prod[1] + r_prod[2];

        r_info.det_neg    <= r_det[DET_W-1];
        r_info.det_zero   <= (r_det == '0);
        r_info.det_mag    <= r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
        r_info.scale_neg  <= i_m[3][3][COORD_W-1];
        r_info.scale_zero <= (i_m[3][3] == '0);
        r_info.scale_mag  <= i_m[3][3][COORD_W-1] ? SCALE_W'(-i_m[3][3])
                                                   : SCALE_W'(i_m[3][3]);
    end

    assign o_adj  = r_adj;
    assign o_info = r_info;

endmodule

`default_nettype wire

// File: hdl/hpt_inv.sv
// hpt_inv: inverse-mode numerators, adjugate times pre-scaled point, in four stages.
// Depends on hpt_pkg.
`default_nettype none

module hpt_inv (
    input  logic                                    i_clk,
    input  hpt_pkg::t_adj                           i_adj [3][3],
    input  logic [2:0][hpt_pkg::QDIV_QW-1:0]        i_qmag,
    input  logic [2:0]                              i_qneg,
    output logic signed [hpt_pkg::NUM_W-1:0]        o_num [3]
);

    import hpt_pkg::*;

    localparam int unsigned QH_W = QS_W - HALF_W;   // signed top part of q

    logic signed [QS_W-1:0]              r_q [3];
    logic signed [HALF_W+QH_W-1:0]       r_hh [3][3];
    logic signed [2*HALF_W:0]            r_hl [3][3];
    logic signed [HALF_W+QH_W:0]         r_lh [3][3];
    logic signed [2*HALF_W+1:0]          r_ll [3][3];
    logic signed [NUM_W-1:0]             r_prod [3][3];
    logic signed [NUM_W-1:0]             r_num [3];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_q[c] <= i_qneg[c] ? -$signed({1'b0, i_qmag[c]}) : $signed({1'b0, i_qmag[c]});
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_hh[r][c] <= $signed(i_adj[r][c][ADJ_W-1:HALF_W])
                              * $signed(r_q[c][QS_W-1:HALF_W]);
                r_hl[r][c] <= $signed(i_adj[r][c][ADJ_W-1:HALF_W])
                              * $signed({1'b0, r_q[c][HALF_W-1:0]});
                r_lh[r][c] <= $signed({1'b0, i_adj[r][c][HALF_W-1:0]})
                              * $signed(r_q[c][QS_W-1:HALF_W]);
                r_ll[r][c] <= $signed({1'b0, i_adj[r][c][HALF_W-1:0]})
                              * $signed({1'b0, r_q[c][HALF_W-1:0]});
                r_prod[r][c] <= (NUM_W'(r_hh[r][c]) <<< (2 * HALF_W))
                              + ((NUM_W'(r_hl[r][c]) + NUM_W'(r_lh[r][c])) <<< HALF_W)
                              + NUM_W'(r_ll[r][c]);
            end
            r_num[r] <= r_prod[r][0] + r_prod[r][1] + r_prod[r][2];
        end
    end

    assign o_num = r_num;

endmodule

`default_nettype wire

// File: hdl/homogeneous_point_transform.sv
// homogeneous_point_transform: top level of the fixed-point 4x4 point transform.
// Depends on hpt_pkg, hpt_div, hpt_mat and hpt_inv.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+----------------------------------------
//  command  | start, busy (taken: start&!busy) | i_opcode, i_in_x, i_in_y, i_in_z
//  result   | o_valid strobe, one cycle        | o_out_x/y/z, o_div_fault, o_saturated
//  config   | i_cfg_valid, o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One transaction enters per clock while busy is low. The two bit-per-stage dividers
// have 49 stages for the inverse pre-scale (p - t) / M33 and 48 for the final divide
// by w or det.
// Synchronous active-low reset clears every valid bit and restores the identity
// matrix; busy is set during reset and cleared at the first edge that sees it released.
// Matrix-derived terms (adjugate, det) settle once a write has passed the hpt_mat registers.
// The receiver takes each result in its strobe cycle, so nothing stalls.
`default_nettype none

module homogeneous_point_transform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic signed [hpt_pkg::COORD_W-1:0]  i_in_x,
    input  logic signed [hpt_pkg::COORD_W-1:0]  i_in_y,
    input  logic signed [hpt_pkg::COORD_W-1:0]  i_in_z,
    output logic                                o_valid,
    output logic signed [hpt_pkg::OUT_W-1:0]    o_out_x,
    output logic signed [hpt_pkg::OUT_W-1:0]    o_out_y,
    output logic signed [hpt_pkg::OUT_W-1:0]    o_out_z,
    output logic                                o_div_fault,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]           i_cfg_data
);

    import hpt_pkg::*;

    // sideband riding through the pre-scale divider
    typedef struct packed {
        t_opcode                  op;
        logic [2:0][COORD_W-1:0]  p;
        logic [2:0]               qneg;
    } t_qpay;

    // sideband riding through the final divider
    typedef struct packed {
        logic        fault;
        logic [2:0]  neg;
        logic [2:0]  ovf;
    } t_fpay;

    localparam int unsigned LAT = 1 + (QDIV_QW + 1) + 4 + 2 + (FDIV_QW + 1) + 1;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_cfg [CFG_N];
    t_entry           w_m [4][4];
    t_adj             w_adj [3][3];
    t_mat_info        w_info;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_RESET;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                r_cfg[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // entry (r, c): register 2r + c/2, odd columns in the high half
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_m[r][c] = ((c & 1) != 0) ? t_entry'(r_cfg[2*r + (c >> 1)][CFG_W-1:COORD_W])
                                           : t_entry'(r_cfg[2*r + (c >> 1)][COORD_W-1:0]);
            end
        end
    end

    hpt_mat u_mat (
        .i_clk  (i_clk),
        .i_m    (w_m),
        .o_adj  (w_adj),
        .o_info (w_info)
    );

    // ---------------- command register ----------------
    logic                       r_a_vld;
    t_opcode                    r_a_op;
    logic signed [COORD_W-1:0]  r_a_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_op   <= t_opcode'(i_opcode);
        r_a_p[0] <= i_in_x;
        r_a_p[1] <= i_in_y;
        r_a_p[2] <= i_in_z;
    end

    // ---------------- inverse pre-scale: (p - t) * 2^16 / M33 ----------------
    localparam int unsigned PW_Q = $bits(t_qpay);

    logic signed [DIFF_W-1:0]       w_diff [3];
    logic [2:0][DIFF_W-1:0]         w_dmag;
    logic [2:0][QDIV_QW-1:0]        w_qlow;
    t_qpay                          w_qin;
    t_qpay                          w_qout;
    logic [PW_Q-1:0]                w_qout_bits;
    logic [2:0][QDIV_QW-1:0]        w_qmag;
    logic                           w_q_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = DIFF_W'(r_a_p[c]) - DIFF_W'(w_m[c][3]);
            w_dmag[c] = w_diff[c][DIFF_W-1] ? DIFF_W'(-w_diff[c]) : DIFF_W'(w_diff[c]);
            w_qlow[c] = {w_dmag[c], FRAC_W'(0)};
            w_qin.p[c]    = r_a_p[c];
            w_qin.qneg[c] = w_diff[c][DIFF_W-1] ^ w_info.scale_neg;
        end
        w_qin.op = r_a_op;
    end

    hpt_div #(
        .LANES (3),
        .DW    (SCALE_W),
        .QW    (QDIV_QW),
        .PW    (PW_Q)
    ) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .i_den   (w_info.scale_mag),
        .i_rem   ('0),
        .i_low   (w_qlow),
        .i_pay   (w_qin),
        .o_valid (w_q_vld),
        .o_quo   (w_qmag),
        .o_pay   (w_qout_bits)
    );

    assign w_qout = t_qpay'(w_qout_bits);

    logic signed [NUM_W-1:0] w_inv_num [3];

    hpt_inv u_inv (
        .i_clk  (i_clk),
        .i_adj  (w_adj),
        .i_qmag (w_qmag),
        .i_qneg (w_qout.qneg),
        .o_num  (w_inv_num)
    );

    // ---------------- forward rows, aligned with the inverse products ----------------
    logic                       r_y1_vld, r_y2_vld, r_f1_vld, r_f2_vld;
    t_opcode                    r_y1_op, r_y2_op, r_f1_op, r_f2_op;
    logic signed [COORD_W-1:0]  r_y1_p [3];
    logic signed [COORD_W-1:0]  r_y2_p [3];
    logic signed [PROD_W-1:0]   r_f1_prod [4][3];
    logic signed [PROD_W-1:0]   r_f1_tr [4];
    logic signed [FROW_W-1:0]   r_f2_row [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y1_vld <= 1'b0;
            r_y2_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else begin
            r_y1_vld <= w_q_vld;
            r_y2_vld <= r_y1_vld;
            r_f1_vld <= r_y2_vld;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y1_op <= w_qout.op;
        r_y2_op <= r_y1_op;
        r_f1_op <= r_y2_op;
        r_f2_op <= r_f1_op;
        for (int c = 0; c < 3; c++) begin
            r_y1_p[c] <= $signed(w_qout.p[c]);
            r_y2_p[c] <= r_y1_p[c];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_f1_prod[r][c] <= $signed(w_m[r][c]) * $signed(r_y2_p[c]);
            end
            r_f1_tr[r]  <= PROD_W'(w_m[r][3]) <<< FRAC_W;    // translation times 1.0
            r_f2_row[r] <= FROW_W'(r_f1_prod[r][0]) + FROW_W'(r_f1_prod[r][1])
                         + FROW_W'(r_f1_prod[r][2]) + FROW_W'(r_f1_tr[r]);
        end
    end

    // ---------------- operand select, magnitudes, fault ----------------
    logic signed [NUM_W-1:0]  w_num [3];
    logic [FROW_W-1:0]        w_fden_mag;
    logic                     w_fden_neg;
    logic                     r_s_vld;
    logic                     r_s_fault;
    logic [2:0]               r_s_neg;
    logic [NUM_W-1:0]         r_s_nmag [3];
    logic [DET_W-1:0]         r_s_dmag;

    always_comb begin
        w_fden_neg = r_f2_row[3][FROW_W-1];
        w_fden_mag = w_fden_neg ? FROW_W'(-r_f2_row[3]) : FROW_W'(r_f2_row[3]);
        for (int r = 0; r < 3; r++) begin
            w_num[r] = (r_f2_op == OP_INV) ? w_inv_num[r] : NUM_W'(r_f2_row[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_s_nmag[r] <= w_num[r][NUM_W-1] ? NUM_W'(-w_num[r]) : NUM_W'(w_num[r]);
            r_s_neg[r]  <= w_num[r][NUM_W-1]
                         ^ ((r_f2_op == OP_INV) ? w_info.det_neg : w_fden_neg);
        end
        if (r_f2_op == OP_INV) begin
            r_s_dmag  <= w_info.det_mag;
            r_s_fault <= w_info.scale_zero || w_info.det_zero;
        end else begin
            r_s_dmag  <= DET_W'(w_fden_mag);
            r_s_fault <= (r_f2_row[3] == '0);
        end
    end

    // ---------------- overflow test: quotient >= 2^48 ----------------
    logic                            r_o_vld;
    t_fpay                           r_o_pay;
    logic [DET_W-1:0]                r_o_dmag;
    logic [2:0][DET_W-1:0]           r_o_rem;
    logic [2:0][FDIV_QW-1:0]         r_o_low;
    logic [2:0]                      w_ovf;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_ovf[r] = (DET_W + OVF_SH)'(r_s_nmag[r]) >= {r_s_dmag, OVF_SH'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_dmag      <= r_s_dmag;
        r_o_pay.fault <= r_s_fault;
        r_o_pay.neg   <= r_s_neg;
        r_o_pay.ovf   <= w_ovf;
        for (int r = 0; r < 3; r++) begin
            r_o_rem[r] <= w_ovf[r] ? '0 : DET_W'(r_s_nmag[r] >> OVF_SH);
            r_o_low[r] <= {r_s_nmag[r][OVF_SH-1:0], FRAC_W'(0)};
        end
    end

    // ---------------- final divide ----------------
    logic                       w_d_vld;
    logic [2:0][FDIV_QW-1:0]    w_quo;
    logic [$bits(t_fpay)-1:0]   w_dpay_bits;
    t_fpay                      w_dpay;

    hpt_div #(
        .LANES (3),
        .DW    (DET_W),
        .QW    (FDIV_QW),
        .PW    ($bits(t_fpay))
    ) u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_o_vld),
        .i_den   (r_o_dmag),
        .i_rem   (r_o_rem),
        .i_low   (r_o_low),
        .i_pay   (r_o_pay),
        .o_valid (w_d_vld),
        .o_quo   (w_quo),
        .o_pay   (w_dpay_bits)
    );

    assign w_dpay = t_fpay'(w_dpay_bits);

    // ---------------- clamp, sign, fault ----------------
    logic [OUT_W-1:0]  w_val [3];
    logic [2:0]        w_sat;
    logic              r_vld;
    logic [OUT_W-1:0]  r_out [3];
    logic              r_fault;
    logic              r_sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sat[r] = 1'b0;
            if (w_dpay.fault) begin
                w_val[r] = '0;
            end else if (!w_dpay.neg[r]) begin
                if (w_dpay.ovf[r] || w_quo[r][FDIV_QW-1]) begin
                    w_val[r] = OUT_MAX;
                    w_sat[r] = 1'b1;
                end else begin
                    w_val[r] = w_quo[r];
                end
            end else begin
                if (w_dpay.ovf[r] || (w_quo[r] > OUT_MIN)) begin
                    w_val[r] = OUT_MIN;
                    w_sat[r] = 1'b1;
                end else begin
                    w_val[r] = OUT_W'(-w_quo[r]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= w_val;
        r_fault <= w_dpay.fault;
        r_sat   <= |w_sat;
    end

    assign o_valid     = r_vld;
    assign o_out_x     = $signed(r_out[0]);
    assign o_out_y     = $signed(r_out[1]);
    assign o_out_z     = $signed(r_out[2]);
    assign o_div_fault = r_fault;
    assign o_saturated = r_sat;

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted transaction produced no result at the expected cycle");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching transaction");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_fault) |->
            (o_out_x == '0 && o_out_y == '0 && o_out_z == '0 && !o_saturated))
        else $error("fault result with nonzero coordinates or saturation");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (r_out[0] == OUT_MAX || r_out[0] == OUT_MIN ||
             r_out[1] == OUT_MAX || r_out[1] == OUT_MIN ||
             r_out[2] == OUT_MAX || r_out[2] == OUT_MIN))
        else $error("saturation flagged but no coordinate at a bound");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench: self-checking bench for homogeneous_point_transform.
// Depends on hdl/hpt_pkg.sv and the RTL under hdl; predicts every result with wide
// signed arithmetic and checks each strobed result against the oldest prediction.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hpt_pkg::*;

    localparam int unsigned LATENCY   = 106;    // base of the final wait before the verdict
    localparam int unsigned SETTLE    = 8;      // matrix terms settle after a write
    localparam int unsigned CYCLE_CAP = 400000;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        t_opcode              op;
        logic signed [31:0]   x, y, z;
    } t_point_cmd;

    typedef struct {
        logic signed [OUT_W-1:0] x, y, z;
        logic                    fault;
        logic                    sat;
    } t_point_res;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_opcode = 1'b0;
    logic signed [COORD_W-1:0]   i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic                        o_valid;
    logic signed [OUT_W-1:0]     o_out_x, o_out_y, o_out_z;
    logic                        o_div_fault, o_saturated;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;

    homogeneous_point_transform DUT (.*);

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Bench copy of the matrix registers, tracked from accepted writes
    logic [CFG_W-1:0] mat_regs [CFG_N];
    initial for (int i = 0; i < CFG_N; i++) mat_regs[i] = CFG_RESET[i];

    t_point_cmd pending_pts [$];
    t_point_res expected_pts [$];
    t_point_cmd on_port;
    int         gap_left = 0;
    bit         gaps_on = 1'b1;
    int         fails = 0;
    int         cycles = 0;

    // ---------------------------------------------------------------- prediction
    function automatic t_wide mat_entry(int r, int c);
        logic [CFG_W-1:0] reg_v;
        logic signed [31:0] half;
        reg_v = mat_regs[r * 2 + c / 2];
        half  = (c % 2) ? reg_v[63:32] : reg_v[31:0];
        return t_wide'(half);
    endfunction

    // Clamp a quotient to Q32.16, flagging any clamp
    function automatic logic signed [OUT_W-1:0] clamp_q3216(t_wide q, ref logic sat);
        if (q > t_wide'(OUT_MAX) && !q[255]) begin
            sat = 1'b1;
            return OUT_MAX;
        end
        if (q < -(t_wide'(1) <<< (OUT_W - 1))) begin
            sat = 1'b1;
            return OUT_MIN;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic t_point_res transform_point(t_point_cmd cmd);
        t_point_res res;
        t_wide      p [3];
        t_wide      num [3];
        t_wide      rows [4];
        t_wide      adj [3][3];
        t_wide      qs [3];
        t_wide      den, scale;
        logic       sat;
        p[0] = t_wide'(cmd.x);
        p[1] = t_wide'(cmd.y);
        p[2] = t_wide'(cmd.z);
        sat = 1'b0;
        res.fault = 1'b0;
        if (cmd.op == OP_FWD) begin
            for (int r = 0; r < 4; r++) begin
                rows[r] = mat_entry(r, 3) * 65536;
                for (int c = 0; c < 3; c++) rows[r] += mat_entry(r, c) * p[c];
            end
            for (int r = 0; r < 3; r++) num[r] = rows[r];
            den = rows[3];
            res.fault = (den == 0);
        end else begin
            scale = mat_entry(3, 3);
            // adjugate of the upper-left 3x3, cofactors taken cyclically
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    adj[r][c] = mat_entry((c+1)%3, (r+1)%3) * mat_entry((c+2)%3, (r+2)%3)
                              - mat_entry((c+1)%3, (r+2)%3) * mat_entry((c+2)%3, (r+1)%3);
            den = mat_entry(0, 0) * adj[0][0] + mat_entry(0, 1) * adj[1][0]
                + mat_entry(0, 2) * adj[2][0];
            res.fault = (scale == 0) || (den == 0);
            if (!res.fault) begin
                for (int c = 0; c < 3; c++) qs[c] = ((p[c] - mat_entry(c, 3)) * 65536) / scale;
                for (int r = 0; r < 3; r++)
                    num[r] = adj[r][0] * qs[0] + adj[r][1] * qs[1] + adj[r][2] * qs[2];
            end
        end
        if (res.fault) begin
            res.x = '0;
            res.y = '0;
            res.z = '0;
        end else begin
            res.x = clamp_q3216((num[0] * 65536) / den, sat);
            res.y = clamp_q3216((num[1] * 65536) / den, sat);
            res.z = clamp_q3216((num[2] * 65536) / den, sat);
        end
        res.sat = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------- command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_pts.push_back(transform_point(on_port));
                void'(pending_pts.pop_front());
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_pts.size() > 0) begin
                    on_port  = pending_pts[0];
                    i_opcode <= on_port.op;
                    i_in_x   <= on_port.x;
                    i_in_y   <= on_port.y;
                    i_in_z   <= on_port.z;
                    start    <= 1'b1;
                    if (gaps_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    always @(posedge i_clk) begin
        t_point_res want;
        if (i_rst_n && o_valid) begin
            if (expected_pts.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                fails++;
            end else begin
                want = expected_pts.pop_front();
                if (o_out_x !== want.x) begin
                    $error("out_x exp %0d got %0d", want.x, o_out_x);
                    fails++;
                end
                if (o_out_y !== want.y) begin
                    $error("out_y exp %0d got %0d", want.y, o_out_y);
                    fails++;
                end
                if (o_out_z !== want.z) begin
                    $error("out_z exp %0d got %0d", want.z, o_out_z);
                    fails++;
                end
                if (o_div_fault !== want.fault) begin
                    $error("div_fault exp %0b got %0b", want.fault, o_div_fault);
                    fails++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated exp %0b got %0b", want.sat, o_saturated);
                    fails++;
                end
            end
        end
    end

    // Register writes land in the bench copy at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) mat_regs[i_cfg_index] = i_cfg_data;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic logic [63:0] pair(logic [31:0] lo, logic [31:0] hi);
        return {hi, lo};
    endfunction

    // Mix of full-range, zero, modest and extreme coordinates
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return 32'sh0;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_small_entry();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    task automatic queue_point(t_opcode op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_point_cmd cmd;
        cmd.op = op;
        cmd.x  = x;
        cmd.y  = y;
        cmd.z  = z;
        pending_pts.push_back(cmd);
    endtask

    task automatic queue_random(int n, bit zero_x);
        for (int i = 0; i < n; i++)
            queue_point($urandom_range(0, 1) ? OP_INV : OP_FWD,
                        (zero_x && $urandom_range(0, 2) == 0) ? 32'h0 : rand_coord(),
                        rand_coord(), rand_coord());
    endtask

    // Wait for every queued transaction to be taken and every result to come back
    task automatic drain();
        while (pending_pts.size() > 0 || expected_pts.size() > 0 || start) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] m [8]);
        drain();
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < CFG_N; i++) write_reg(i, m[i]);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] m [8];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset identity: field extremes, both operations
        queue_point(OP_FWD, 32'h0, 32'h0, 32'h0);
        queue_point(OP_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_point(OP_INV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        queue_point(OP_INV, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000);
        queue_point(OP_FWD, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_8000);
        queue_point(OP_INV, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_8000);
        drain();

        // Projective row picks w = x: zero w when x is zero
        m = '{pair(32'h1_0000, 0), pair(0, 32'h2_0000), pair(0, 32'h1_0000), pair(0, 0),
              pair(0, 0), pair(32'h1_0000, 32'hFFFF_0000), pair(32'h1_0000, 0), pair(0, 0)};
        load_matrix(m);
        queue_point(OP_FWD, 32'h0, 32'h1234_5678, 32'h0);
        queue_point(OP_FWD, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_point(OP_FWD, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        // M33 zero: inverse faults on scale
        queue_point(OP_INV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        queue_random(80, 1'b1);

        // Singular block with nonzero scale: inverse faults on det
        m = '{pair(32'h1_0000, 32'h2_0000), pair(32'h3_0000, 32'h1_0000),
              pair(32'h2_0000, 32'h4_0000), pair(32'h6_0000, 32'hFFFF_0000),
              pair(32'h5_0000, 32'h7_0000), pair(32'h9_0000, 0),
              pair(0, 0), pair(0, 32'h2_0000)};
        load_matrix(m);
        queue_random(60, 1'b0);

        // All entries at the most negative value, then the most positive
        for (int i = 0; i < CFG_N; i++) m[i] = 64'h8000_0000_8000_0000;
        load_matrix(m);
        queue_random(50, 1'b0);
        for (int i = 0; i < CFG_N; i++) m[i] = 64'h7FFF_FFFF_7FFF_FFFF;
        load_matrix(m);
        queue_random(50, 1'b0);

        // Full-range random matrix
        for (int i = 0; i < CFG_N; i++) m[i] = {$urandom(), $urandom()};
        load_matrix(m);
        queue_random(100, 1'b0);

        // Modest matrix; sender holds off mid-stream until every result is back
        for (int i = 0; i < CFG_N; i++) m[i] = pair(rand_small_entry(), rand_small_entry());
        load_matrix(m);
        queue_random(75, 1'b0);
        drain();
        queue_random(75, 1'b0);

        // Last phase back-to-back, no gaps
        for (int i = 0; i < CFG_N; i++) m[i] = pair(rand_small_entry(), rand_small_entry());
        load_matrix(m);
        gaps_on = 1'b0;
        queue_random(200, 1'b0);
        drain();

        repeat (LATENCY + 20) @(posedge i_clk);
        if (fails == 0 && expected_pts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
